@@ src/hpd_pkg.sv @@
`timescale 1ns / 1ps

package hpd_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned MODE_WIDTH     = 3;

   localparam logic [MODE_WIDTH-1:0] FMT_PLANAR8 = 3'd0;
   localparam logic [MODE_WIDTH-1:0] FMT_YUY2    = 3'd1;
   localparam logic [MODE_WIDTH-1:0] FMT_RGB555  = 3'd2;
   localparam logic [MODE_WIDTH-1:0] FMT_RGB565  = 3'd3;
   localparam logic [MODE_WIDTH-1:0] FMT_RGB24   = 3'd4;
   localparam logic [MODE_WIDTH-1:0] FMT_RGB32   = 3'd5;

   localparam logic [0:0] REG_FORMAT_MODE = 1'b0;

   typedef struct packed {
      logic [31:0] pixel_word;
      logic        row_end;
   } req_type;

   typedef struct packed {
      logic [31:0] first_out;
      logic [31:0] second_out;
      logic        last_of_row;
   } rsp_type;

   function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   function automatic logic [5:0] avg6(input logic [5:0] a, input logic [5:0] b);
      logic [6:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[6:1];
   endfunction

   function automatic logic [4:0] avg5(input logic [4:0] a, input logic [4:0] b);
      logic [5:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[5:1];
   endfunction

endpackage

@@ src/hpd_pair_calc.sv @@
`timescale 1ns / 1ps

module hpd_pair_calc
   import hpd_pkg::*;
(
   input  logic [MODE_WIDTH-1:0] format_mode,
   input  logic [31:0]           base_pixel,
   input  logic [31:0]           next_pixel,
   input  logic                  row_end_pair,
   output logic [31:0]           first_out,
   output logic [31:0]           second_out
);

   logic [31:0] even_word;
   logic [31:0] interp_word;
   logic [31:0] end_word;

   always_comb begin
      even_word   = base_pixel;
      interp_word = '0;
      end_word    = base_pixel;
      unique case (format_mode)
         FMT_PLANAR8: begin
            even_word   = {24'd0, base_pixel[7:0]};
            end_word    = even_word;
            interp_word = {24'd0, avg8(base_pixel[7:0], next_pixel[7:0])};
         end
         FMT_YUY2: begin
            even_word   = {base_pixel[31:24], avg8(base_pixel[7:0], base_pixel[23:16]),
                           base_pixel[15:8], base_pixel[7:0]};
            interp_word = {avg8(base_pixel[31:24], next_pixel[31:24]),
                           avg8(base_pixel[23:16], next_pixel[7:0]),
                           avg8(base_pixel[15:8], next_pixel[15:8]),
                           base_pixel[23:16]};
            end_word    = {base_pixel[31:24], base_pixel[23:16],
                           base_pixel[15:8], base_pixel[23:16]};
         end
         FMT_RGB555: begin
            even_word   = {16'd0, base_pixel[15:0]};
            end_word    = even_word;
            interp_word = {17'd0, avg5(base_pixel[14:10], next_pixel[14:10]),
                           avg5(base_pixel[9:5], next_pixel[9:5]),
                           avg5(base_pixel[4:0], next_pixel[4:0])};
         end
         FMT_RGB565: begin
            even_word   = {16'd0, base_pixel[15:0]};
            end_word    = even_word;
            interp_word = {16'd0, avg5(base_pixel[15:11], next_pixel[15:11]),
                           avg6(base_pixel[10:5], next_pixel[10:5]),
                           avg5(base_pixel[4:0], next_pixel[4:0])};
         end
         FMT_RGB24: begin
            even_word   = {8'd0, base_pixel[23:0]};
            end_word    = even_word;
            interp_word = {8'd0, avg8(base_pixel[23:16], next_pixel[23:16]),
                           avg8(base_pixel[15:8], next_pixel[15:8]),
                           avg8(base_pixel[7:0], next_pixel[7:0])};
         end
         default: begin
            // RGB32 and the unused codes average all four bytes.
            interp_word = {avg8(base_pixel[31:24], next_pixel[31:24]),
                           avg8(base_pixel[23:16], next_pixel[23:16]),
                           avg8(base_pixel[15:8], next_pixel[15:8]),
                           avg8(base_pixel[7:0], next_pixel[7:0])};
         end
      endcase
   end

   assign first_out  = even_word;
   assign second_out = row_end_pair ? end_word : interp_word;

endmodule

@@ src/horizontal_pixel_doubler_core.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_type (pixel_word, row_end)
// rsp      out        rsp_valid/rsp_ready  rsp_type (first_out, second_out, last_of_row)
// csr      in         APB write/read       format_mode at byte address 0
//
// An item is registered on acceptance; its results move from the first stage into the
// output register when it is free. One item per cycle is taken unless the first stage
// is busy; a row end with a pixel held yields two results and holds that stage for both.
// Reset is synchronous and clears the held pixel, the stages and the format register.
// A stalled result holds the output register, and the input stage stalls behind it.

module horizontal_pixel_doubler_core
   import hpd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [MODE_WIDTH-1:0] mode_ff, mode_in;
   logic [31:0]           held_ff, held_in;
   logic                  held_valid_ff, held_valid_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [31:0]           s1_held_ff, s1_held_in;
   logic [31:0]           s1_pixel_ff, s1_pixel_in;
   logic                  s1_hv_ff, s1_hv_in;
   logic                  s1_last_ff, s1_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic        csr_write;
   logic        accept;
   logic        out_load;
   logic        s1_emit;
   logic        s1_final;
   logic [31:0] calc_first;
   logic [31:0] calc_second;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_FORMAT_MODE)
                      ? {{(CSR_DATA_WIDTH-MODE_WIDTH){1'b0}}, mode_ff} : '0;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign s1_emit   = s1_valid_ff && out_load;
   assign s1_final  = !(s1_hv_ff && s1_last_ff);
   assign req_ready = !s1_valid_ff || (s1_emit && s1_final);
   assign accept    = req_valid && req_ready;

   hpd_pair_calc u_calc (
      .format_mode  (mode_ff),
      .base_pixel   (s1_hv_ff ? s1_held_ff : s1_pixel_ff),
      .next_pixel   (s1_pixel_ff),
      .row_end_pair (!s1_hv_ff),
      .first_out    (calc_first),
      .second_out   (calc_second)
   );

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && paddr[2] == REG_FORMAT_MODE) begin
         mode_in = pwdata[MODE_WIDTH-1:0];
      end

      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      if (accept) begin
         held_in       = req_data.row_end ? 32'd0 : req_data.pixel_word;
         held_valid_in = !req_data.row_end;
      end

      s1_valid_in = s1_valid_ff;
      s1_held_in  = s1_held_ff;
      s1_pixel_in = s1_pixel_ff;
      s1_hv_in    = s1_hv_ff;
      s1_last_in  = s1_last_ff;
      if (accept && (held_valid_ff || req_data.row_end)) begin
         s1_valid_in = 1'b1;
         s1_held_in  = held_ff;
         s1_pixel_in = req_data.pixel_word;
         s1_hv_in    = held_valid_ff;
         s1_last_in  = req_data.row_end;
      end else if (s1_emit && s1_final) begin
         s1_valid_in = 1'b0;
      end else if (s1_emit) begin
         s1_hv_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (s1_emit) begin
         rsp_data_in.first_out   = calc_first;
         rsp_data_in.second_out  = calc_second;
         rsp_data_in.last_of_row = !s1_hv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= FMT_PLANAR8;
         held_valid_ff <= 1'b0;
         held_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         held_valid_ff <= held_valid_in;
         held_ff       <= held_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_held_ff  <= s1_held_in;
      s1_pixel_ff <= s1_pixel_in;
      s1_hv_ff    <= s1_hv_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ dv/horizontal_pixel_doubler_core_tb.sv @@
`timescale 1ns / 1ps

module horizontal_pixel_doubler_core_tb;
   import hpd_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_ITEMS  = 95;
   localparam int PHASE_COUNT  = 8;
   localparam int UNUSED_REG   = 1;

   localparam logic [CSR_ADDR_WIDTH-1:0] FORMAT_ADDR = CSR_ADDR_WIDTH'(4 * REG_FORMAT_MODE);
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_ADDR  = CSR_ADDR_WIDTH'(4 * UNUSED_REG);

   localparam logic [MODE_WIDTH-1:0] FMT_UNDEF6 = 3'd6;
   localparam logic [MODE_WIDTH-1:0] FMT_UNDEF7 = 3'd7;

   localparam logic [31:0] RGB555_RED   = 32'h7c00;
   localparam logic [31:0] RGB555_GREEN = 32'h03e0;
   localparam logic [31:0] RGB565_RED   = 32'hf800;
   localparam logic [31:0] RGB565_GREEN = 32'h07e0;
   localparam logic [31:0] RGB_BLUE     = 32'h001f;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   logic [MODE_WIDTH-1:0] mode_shadow = FMT_PLANAR8;
   logic [31:0]           held_word = '0;
   logic                  held_live = 1'b0;

   req_type pixel_queue[$];
   rsp_type predicted_pairs[$];
   rsp_type want;

   int send_gap = 0;
   int hold_gap = 0;
   int error_count = 0;
   int cycle_count = 0;
   bit req_gaps_on = 1'b0;
   bit rsp_gaps_on = 1'b0;

   horizontal_pixel_doubler_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] mean8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] total;
      total = a + b;
      return total[8:1];
   endfunction

   function automatic logic [31:0] field_mean(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] m);
      return (((a & m) + (b & m)) >> 1) & m;
   endfunction

   function automatic logic [31:0] width_mask(input logic [MODE_WIDTH-1:0] f);
      case (f)
         FMT_PLANAR8: return 32'h0000_00ff;
         FMT_RGB555, FMT_RGB565: return 32'h0000_ffff;
         FMT_RGB24: return 32'h00ff_ffff;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   function automatic logic [31:0] even_word(input logic [MODE_WIDTH-1:0] f,
                                             input logic [31:0] h);
      if (f == FMT_YUY2) begin
         return {h[31:24], mean8(h[7:0], h[23:16]), h[15:8], h[7:0]};
      end
      return h & width_mask(f);
   endfunction

   function automatic logic [31:0] end_word(input logic [MODE_WIDTH-1:0] f,
                                            input logic [31:0] h);
      if (f == FMT_YUY2) begin
         return {h[31:24], h[23:16], h[15:8], h[23:16]};
      end
      return h & width_mask(f);
   endfunction

   function automatic logic [31:0] interp_word(input logic [MODE_WIDTH-1:0] f,
                                               input logic [31:0] h, input logic [31:0] n);
      case (f)
         FMT_PLANAR8: return {24'h0, mean8(h[7:0], n[7:0])};
         FMT_YUY2: return {mean8(h[31:24], n[31:24]), mean8(h[23:16], n[7:0]),
                           mean8(h[15:8], n[15:8]), h[23:16]};
         FMT_RGB555: return field_mean(h, n, RGB555_RED) | field_mean(h, n, RGB555_GREEN) |
                            field_mean(h, n, RGB_BLUE);
         FMT_RGB565: return field_mean(h, n, RGB565_RED) | field_mean(h, n, RGB565_GREEN) |
                            field_mean(h, n, RGB_BLUE);
         FMT_RGB24: return {8'h0, mean8(h[23:16], n[23:16]), mean8(h[15:8], n[15:8]),
                            mean8(h[7:0], n[7:0])};
         default: return {mean8(h[31:24], n[31:24]), mean8(h[23:16], n[23:16]),
                          mean8(h[15:8], n[15:8]), mean8(h[7:0], n[7:0])};
      endcase
   endfunction

   task automatic double_pixel(input req_type item);
      rsp_type pair;
      if (held_live) begin
         pair.first_out   = even_word(mode_shadow, held_word);
         pair.second_out  = interp_word(mode_shadow, held_word, item.pixel_word);
         pair.last_of_row = 1'b0;
         predicted_pairs.push_back(pair);
      end
      if (item.row_end) begin
         pair.first_out   = even_word(mode_shadow, item.pixel_word);
         pair.second_out  = end_word(mode_shadow, item.pixel_word);
         pair.last_of_row = 1'b1;
         predicted_pairs.push_back(pair);
         held_word = '0;
         held_live = 1'b0;
      end else begin
         held_word = item.pixel_word;
         held_live = 1'b1;
      end
   endtask

   function automatic void queue_pixel(input logic [31:0] word, input logic row_last);
      req_type item;
      item.pixel_word = word;
      item.row_end    = row_last;
      pixel_queue.push_back(item);
   endfunction

   task automatic wait_idle();
      int calm;
      calm = 0;
      while (calm < DRAIN_CYCLES) begin
         @(negedge clock);
         if (pixel_queue.size() == 0 && !req_valid && predicted_pairs.size() == 0) begin
            calm++;
         end else begin
            calm = 0;
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [MODE_WIDTH-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CSR_DATA_WIDTH'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == FORMAT_ADDR) begin
         mode_shadow = value;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      psel  <= 1'b1;
      paddr <= FORMAT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_WIDTH'(mode_shadow)) begin
         $display("%0t: format_mode readback expected %h, got %h", $time,
                  CSR_DATA_WIDTH'(mode_shadow), prdata);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            double_pixel(req_data);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               req_data  <= pixel_queue.pop_front();
               req_valid <= 1'b1;
               if (req_gaps_on && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 19);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_pairs.size() == 0) begin
               $display("%0t: unexpected item, expected none, got %h", $time, rsp_data);
               error_count++;
            end else begin
               want = predicted_pairs.pop_front();
               if (rsp_data.first_out !== want.first_out) begin
                  $display("%0t: first_out expected %h, got %h", $time,
                           want.first_out, rsp_data.first_out);
                  error_count++;
               end
               if (rsp_data.second_out !== want.second_out) begin
                  $display("%0t: second_out expected %h, got %h", $time,
                           want.second_out, rsp_data.second_out);
                  error_count++;
               end
               if (rsp_data.last_of_row !== want.last_of_row) begin
                  $display("%0t: last_of_row expected %b, got %b", $time,
                           want.last_of_row, rsp_data.last_of_row);
                  error_count++;
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
               hold_gap = $urandom_range(1, 19);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [MODE_WIDTH-1:0] format_plan [0:PHASE_COUNT-1];
      int count;
      int len;
      logic [31:0] word;
      format_plan = '{FMT_RGB32, FMT_PLANAR8, FMT_YUY2, FMT_RGB555,
                      FMT_RGB565, FMT_RGB24, FMT_YUY2, FMT_RGB32};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A row of one item, then a short row in the reset format.
      queue_pixel(32'hffff_ffff, 1'b1);
      queue_pixel(32'h0000_0000, 1'b0);
      queue_pixel(32'hffff_ffff, 1'b0);
      queue_pixel(32'h0000_00fe, 1'b1);
      wait_idle();
      write_csr(FORMAT_ADDR, FMT_YUY2);
      queue_pixel(32'hffff_ffff, 1'b0);
      queue_pixel(32'h0000_0000, 1'b0);
      queue_pixel(32'h80ff_01fe, 1'b1);
      wait_idle();
      write_csr(FORMAT_ADDR, FMT_RGB555);
      queue_pixel(32'hffff_ffff, 1'b0);
      queue_pixel(32'hffff_7fff, 1'b1);
      wait_idle();
      write_csr(FORMAT_ADDR, FMT_RGB565);
      queue_pixel(32'hffff_ffff, 1'b0);
      queue_pixel(32'h0000_0821, 1'b0);
      queue_pixel(32'h0000_f81f, 1'b1);
      wait_idle();
      write_csr(FORMAT_ADDR, FMT_RGB24);
      queue_pixel(32'h00ff_ffff, 1'b0);
      queue_pixel(32'hff00_0001, 1'b1);
      wait_idle();
      write_csr(FORMAT_ADDR, FMT_RGB32);
      queue_pixel(32'hffff_ffff, 1'b0);
      queue_pixel(32'h0101_0101, 1'b1);
      wait_idle();
      write_csr(FORMAT_ADDR, FMT_UNDEF6);
      queue_pixel(32'hffff_ffff, 1'b0);
      queue_pixel(32'h0000_0000, 1'b1);
      wait_idle();
      write_csr(FORMAT_ADDR, FMT_UNDEF7);
      queue_pixel(32'h1234_5678, 1'b0);
      queue_pixel(32'hfedc_ba98, 1'b1);
      wait_idle();
      write_csr(SPARE_ADDR, FMT_RGB565);

      // The format changes while a pixel is held in the middle of a row.
      queue_pixel(32'haaaa_aaaa, 1'b0);
      wait_idle();
      write_csr(FORMAT_ADDR, FMT_PLANAR8);
      queue_pixel(32'h5555_5555, 1'b1);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         write_csr(FORMAT_ADDR, format_plan[phase]);
         req_gaps_on = (phase < PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
         rsp_gaps_on = (phase < PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
         count = 0;
         while (count < PHASE_ITEMS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 1; i <= len; i++) begin
               case ($urandom_range(0, 7))
                  0: word = '0;
                  1: word = '1;
                  default: word = $urandom();
               endcase
               queue_pixel(word, i == len);
            end
            count += len;
         end
         if (phase < PHASE_COUNT - 1 && $urandom_range(0, 1) == 1) begin
            queue_pixel($urandom(), 1'b0);
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
